>>> hdl/markup_title_extractor_defines.svh
// assertion macros for the markup title extractor
`ifndef MARKUP_TITLE_EXTRACTOR_DEFINES_SVH
`define MARKUP_TITLE_EXTRACTOR_DEFINES_SVH

`ifndef SYNTH
// clocked check, off while reset is asserted
`define MTE_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mte check failed");
// clocked check that also holds during reset
`define MTE_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("mte check failed");
`else
`define MTE_ASSERT(label, prop)
`define MTE_ASSERT_ALWAYS(label, prop)
`endif

`endif

>>> hdl/mte_pkg.sv
package mte_pkg;

    // tag scanner phase
    typedef enum logic [3:0] {
        PH_TEXT       = 4'd0,
        PH_AFTER_LT   = 4'd1,
        PH_CMT_PFX    = 4'd2,
        PH_NAME       = 4'd3,
        PH_BODY       = 4'd4,
        PH_NAMED_BODY = 4'd5,
        PH_CMT0       = 4'd6,
        PH_CMT1       = 4'd7,
        PH_CMT2       = 4'd8
    } scan_phase_t;

    // controller states
    typedef enum logic [1:0] {
        CTL_SCAN    = 2'd0,
        CTL_EMIT_RD = 2'd1,
        CTL_EMIT_WR = 2'd2
    } ctl_state_t;

    // controller to datapath
    typedef struct packed {
        logic step;     // take the presented byte
        logic read;     // read title store at the emit index
        logic load;     // load one title char into the output register
    } mte_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic direct;     // this byte gives a single result at once
        logic title;      // this byte starts a title emission
        logic last_char;  // emit index is at the final char
    } mte_status_t;

    localparam logic [6:0]  CNT_SAT  = 7'd127;
    localparam logic [16:0] LINE_SAT = 17'h1FFFF;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_T     = 8'h74;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SP) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
    endfunction

    // expected char of "title" or "/title" at a match position
    function automatic logic [7:0] name_char(input logic closing, input logic [2:0] pos);
        logic [2:0] idx;
        idx = closing ? pos : pos + 3'd1;
        case (idx)
            3'd0:    return CH_SLASH;
            3'd1:    return 8'h74;
            3'd2:    return 8'h69;
            3'd3:    return 8'h74;
            3'd4:    return 8'h6C;
            3'd5:    return 8'h65;
            default: return 8'h00;
        endcase
    endfunction

endpackage

>>> hdl/mte_ctrl.sv
`include "markup_title_extractor_defines.svh"

module mte_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  mte_pkg::mte_status_t st,
    output mte_pkg::mte_cmd_t    cmd
);
    import mte_pkg::*;

    ctl_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CTL_SCAN:
            begin
                if (in_valid && out_free && st.title)
                    state_next = CTL_EMIT_RD;
            end
            CTL_EMIT_RD:
                state_next = CTL_EMIT_WR;
            CTL_EMIT_WR:
            begin
                if (out_free)
                    state_next = st.last_char ? CTL_SCAN : CTL_EMIT_RD;
            end
            default:
                state_next = CTL_SCAN;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            CTL_SCAN:
            begin
                in_stall = !out_free;
                cmd.step = in_valid && out_free;
            end
            CTL_EMIT_RD:
                cmd.read = 1'b1;
            CTL_EMIT_WR:
                cmd.load = out_free;
            default:
                in_stall = 1'b1;
        endcase
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.load || (cmd.step && st.direct))
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CTL_SCAN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `MTE_ASSERT(a_stall_while_emit, (state_reg != CTL_SCAN) |-> in_stall)
    `MTE_ASSERT(a_wr_after_rd, (state_reg == CTL_EMIT_WR) |-> $past(state_reg != CTL_SCAN))
    `MTE_ASSERT(a_load_sets_valid, cmd.load |=> out_valid_reg)
    `MTE_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_reg == CTL_SCAN && !out_valid_reg))

endmodule

>>> hdl/mte_dp.sv
module mte_dp #(
    parameter int TITLE_MAX = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_wdata,
    input  logic [7:0]           text_byte,
    input  logic                 start_of_file,
    input  logic                 end_of_file,
    input  mte_pkg::mte_cmd_t    cmd,
    output mte_pkg::mte_status_t st,
    output logic [7:0]           title_char,
    output logic [6:0]           title_length,
    output logic                 found,
    output logic                 is_last
);
    import mte_pkg::*;

    localparam int         AW    = $clog2(TITLE_MAX);
    localparam logic [6:0] TMAX7 = 7'(TITLE_MAX);
    localparam logic [6:0] TDOT  = 7'(TITLE_MAX - 3);

    // scanner state
    scan_phase_t phase_reg, phase_next;
    logic [2:0]  pos_reg, pos_next;
    logic        open_reg, open_next;
    logic [16:0] line_reg, line_next;
    logic [7:0]  quote_reg, quote_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [6:0]  last_reg, last_next;
    logic [6:0]  mark_reg, mark_next;
    logic        ans_reg, ans_next;
    logic [15:0] limit_reg;

    // title store and emit path
    logic [7:0]    mem [TITLE_MAX];
    logic [7:0]    rdata_reg;
    logic [AW-1:0] k_reg;
    logic [6:0]    len_reg;
    logic          trunc_reg;
    logic [7:0]    char_reg;
    logic [6:0]    length_reg;
    logic          found_reg;
    logic          last_flag_reg;

    // effective state after start of file
    scan_phase_t e_phase;
    logic [2:0]  e_pos;
    logic        e_open;
    logic [16:0] e_line;
    logic [7:0]  e_quote;
    logic [6:0]  e_cnt, e_last, e_mark;
    logic        e_ans;

    logic [7:0]  b, lb;
    logic        ws;
    logic        we;
    logic [6:0]  cnt_inc;
    logic [16:0] line_inc;
    logic [2:0]  pos_inc, tlen;
    logic        tb_end;
    logic [7:0]  tb_quote;
    logic        emit_none, emit_title;
    logic        trunc;
    logic [6:0]  len;
    logic [6:0]  k7;
    logic        dot;
    logic [7:0]  emit_ch;

    assign b  = text_byte;
    assign lb = fold_case(text_byte);
    assign ws = is_ws(text_byte);

    assign e_phase = start_of_file ? PH_TEXT : phase_reg;
    assign e_pos   = start_of_file ? 3'd0  : pos_reg;
    assign e_open  = start_of_file ? 1'b0  : open_reg;
    assign e_line  = start_of_file ? 17'd0 : line_reg;
    assign e_quote = start_of_file ? 8'd0  : quote_reg;
    assign e_cnt   = start_of_file ? 7'd0  : cnt_reg;
    assign e_last  = start_of_file ? 7'd0  : last_reg;
    assign e_mark  = start_of_file ? 7'd0  : mark_reg;
    assign e_ans   = start_of_file ? 1'b0  : ans_reg;

    // quote-aware tag body
    always_comb
    begin
        tb_end   = 1'b0;
        tb_quote = e_quote;
        if (e_quote != 8'd0)
        begin
            if (b == e_quote)
                tb_quote = 8'd0;
        end
        else if (b == CH_DQ || b == CH_SQ)
            tb_quote = b;
        else
            tb_end = (b == CH_GT);
    end

    assign cnt_inc  = (e_cnt < CNT_SAT) ? e_cnt + 7'd1 : e_cnt;
    assign line_inc = (e_line < LINE_SAT) ? e_line + 17'd1 : e_line;
    assign pos_inc  = e_pos + 3'd1;
    assign tlen     = e_open ? 3'd6 : 3'd5;

    // byte scanner
    always_comb
    begin
        phase_next = e_phase;
        pos_next   = e_pos;
        open_next  = e_open;
        line_next  = e_line;
        quote_next = e_quote;
        cnt_next   = e_cnt;
        last_next  = e_last;
        mark_next  = e_mark;
        ans_next   = e_ans;
        we         = 1'b0;
        emit_none  = 1'b0;
        emit_title = 1'b0;
        if (!e_ans)
        begin
            // title content capture
            if (e_open)
            begin
                if (e_phase == PH_TEXT && b == CH_LT)
                    mark_next = e_last;
                if (!(e_cnt == 7'd0 && ws))
                begin
                    we       = (e_cnt < TMAX7);
                    cnt_next = cnt_inc;
                    if (!ws)
                        last_next = cnt_inc;
                end
            end
            case (e_phase)
                PH_TEXT:
                begin
                    if (b == CH_LF)
                    begin
                        line_next = line_inc;
                        if (line_inc > {1'b0, limit_reg})
                            emit_none = 1'b1;
                    end
                    if (b == CH_LT)
                    begin
                        phase_next = PH_AFTER_LT;
                        quote_next = 8'd0;
                    end
                end
                PH_AFTER_LT:
                begin
                    if (b == CH_BANG)
                    begin
                        phase_next = PH_CMT_PFX;
                        pos_next   = 3'd1;
                    end
                    else if ((!e_open && lb == CH_T) || (e_open && b == CH_SLASH))
                    begin
                        phase_next = PH_NAME;
                        pos_next   = 3'd1;
                    end
                    else
                    begin
                        quote_next = tb_quote;
                        phase_next = tb_end ? PH_TEXT : PH_BODY;
                    end
                end
                PH_CMT_PFX:
                begin
                    if (b == CH_DASH)
                    begin
                        pos_next = pos_inc;
                        if (pos_inc >= 3'd3)
                            phase_next = PH_CMT0;
                    end
                    else
                    begin
                        quote_next = tb_quote;
                        phase_next = tb_end ? PH_TEXT : PH_BODY;
                    end
                end
                PH_NAME:
                begin
                    if (e_pos < tlen && lb == name_char(e_open, e_pos))
                    begin
                        pos_next = pos_inc;
                        if (pos_inc >= tlen)
                            phase_next = PH_NAMED_BODY;
                    end
                    else
                    begin
                        quote_next = tb_quote;
                        phase_next = tb_end ? PH_TEXT : PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    quote_next = tb_quote;
                    if (tb_end)
                        phase_next = PH_TEXT;
                end
                PH_NAMED_BODY:
                begin
                    quote_next = tb_quote;
                    if (tb_end)
                    begin
                        if (!e_open)
                        begin
                            open_next  = 1'b1;
                            cnt_next   = 7'd0;
                            last_next  = 7'd0;
                            mark_next  = 7'd0;
                            phase_next = PH_TEXT;
                        end
                        else
                            emit_title = 1'b1;
                    end
                end
                PH_CMT0:
                begin
                    if (b == CH_DASH)
                        phase_next = PH_CMT1;
                end
                PH_CMT1:
                begin
                    if (b == CH_DASH)
                        phase_next = PH_CMT1;
                    else if (ws)
                        phase_next = PH_CMT2;
                    else if (b == CH_GT)
                        phase_next = PH_TEXT;
                    else
                        phase_next = PH_CMT0;
                end
                PH_CMT2:
                begin
                    if (ws)
                        phase_next = PH_CMT2;
                    else if (b == CH_GT)
                        phase_next = PH_TEXT;
                    else
                        phase_next = PH_CMT0;
                end
                default:
                    phase_next = PH_TEXT;
            endcase
            // end of file answer
            if (!emit_none && !emit_title && end_of_file)
            begin
                if (phase_next == PH_NAMED_BODY && open_next)
                    emit_title = 1'b1;
                else
                    emit_none = 1'b1;
            end
            if (emit_none || emit_title)
                ans_next = 1'b1;
        end
    end

    // answer length with truncation
    assign trunc = mark_next > TMAX7;
    assign len   = trunc ? TMAX7 : mark_next;

    assign st.direct    = emit_none || (emit_title && len == 7'd0);
    assign st.title     = emit_title && len != 7'd0;
    assign k7           = 7'(k_reg);
    assign st.last_char = (k7 + 7'd1) == len_reg;

    // char for the emit index
    assign dot     = trunc_reg && (k7 >= TDOT);
    assign emit_ch = dot ? CH_DOT : (is_ws(rdata_reg) ? CH_SP : rdata_reg);

    // scanner registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TEXT;
            pos_reg   <= 3'd0;
            open_reg  <= 1'b0;
            line_reg  <= 17'd0;
            quote_reg <= 8'd0;
            cnt_reg   <= 7'd0;
            last_reg  <= 7'd0;
            mark_reg  <= 7'd0;
            ans_reg   <= 1'b0;
        end
        else if (cmd.step)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            open_reg  <= open_next;
            line_reg  <= line_next;
            quote_reg <= quote_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            mark_reg  <= mark_next;
            ans_reg   <= ans_next;
        end
    end

    // line limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= 16'd12;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    // title store
    always_ff @(posedge clk)
    begin
        if (cmd.step && we)
            mem[e_cnt[AW-1:0]] <= b;
        if (cmd.read)
            rdata_reg <= mem[k_reg];
    end

    // emit index and output register
    always_ff @(posedge clk)
    begin
        if (cmd.step && st.title)
        begin
            k_reg     <= '0;
            len_reg   <= len;
            trunc_reg <= trunc;
        end
        else if (cmd.load)
            k_reg <= k_reg + 1'b1;

        if (cmd.step && st.direct)
        begin
            char_reg      <= 8'd0;
            length_reg    <= 7'd0;
            found_reg     <= emit_title;
            last_flag_reg <= 1'b1;
        end
        else if (cmd.load)
        begin
            char_reg      <= emit_ch;
            length_reg    <= len_reg;
            found_reg     <= 1'b1;
            last_flag_reg <= st.last_char;
        end
    end

    assign title_char   = char_reg;
    assign title_length = length_reg;
    assign found        = found_reg;
    assign is_last      = last_flag_reg;

endmodule

>>> hdl/markup_title_extractor.sv
// channel   direction  handshake            payload
// cfg       in         cfg_we               cfg_wdata (title_line_limit)
// in        in         in_valid / in_stall  text_byte, start_of_file, end_of_file
// out       out        out_valid / out_stall title_char, title_length, found, is_last
//
// one byte per cycle while scanning; a byte is taken whenever the output register is free
// a title goes out char by char, each read from the title store then loaded, input held
// rst_n clears scanner and controller, line limit returns to 12; title store is not cleared
// out_stall holds the output register and blocks new bytes only when it is full
module markup_title_extractor #(
    parameter int TITLE_MAX = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_byte,
    input  logic        start_of_file,
    input  logic        end_of_file,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  title_char,
    output logic [6:0]  title_length,
    output logic        found,
    output logic        is_last
);
    import mte_pkg::*;

    mte_cmd_t    cmd;
    mte_status_t st;

    // handshake sequencing
    mte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    // scanner, title store and output register
    mte_dp #(
        .TITLE_MAX (TITLE_MAX)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .text_byte     (text_byte),
        .start_of_file (start_of_file),
        .end_of_file   (end_of_file),
        .cmd           (cmd),
        .st            (st),
        .title_char    (title_char),
        .title_length  (title_length),
        .found         (found),
        .is_last       (is_last)
    );

endmodule

>>> verif/markup_title_extractor_test.sv
module markup_title_extractor_test;
    import mte_pkg::*;

    // one expected title result
    typedef struct {
        logic [7:0] ch;
        logic [6:0] len;
        logic       fnd;
        logic       last;
    } title_res_t;

    // predicts title results per byte and checks the block's output against them
    class title_scoreboard;
        bit [15:0]   line_limit = 16'd12;
        scan_phase_t phase = PH_TEXT;
        bit [2:0]    match_pos;
        bit          open_seen;
        bit [16:0]   lines;
        bit [7:0]    quote;
        bit [7:0]    store [64];
        bit [6:0]    cnt;
        bit [6:0]    last_cnt;
        bit [6:0]    mark_cnt;
        bit          done;
        title_res_t  title_q [$];
        int          errors;

        function bit white(bit [7:0] b);
            return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
        endfunction

        function bit [7:0] low_case(bit [7:0] b);
            return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        endfunction

        function void clear_file();
            phase = PH_TEXT;
            match_pos = 0;
            open_seen = 0;
            lines = 0;
            quote = 0;
            cnt = 0;
            last_cnt = 0;
            mark_cnt = 0;
            done = 0;
        endfunction

        function void keep_byte(bit [7:0] b);
            if (cnt == 0 && white(b))
                return;
            if (cnt < 64)
                store[cnt[5:0]] = b;
            if (cnt < 7'd127)
                cnt++;
            if (!white(b))
                last_cnt = cnt;
        endfunction

        // quote-aware body; 1 on the '>' that closes the tag
        function bit body_end(bit [7:0] b);
            if (quote != 0) begin
                if (b == quote)
                    quote = 0;
                return 0;
            end
            if (b == "\"" || b == "'") begin
                quote = b;
                return 0;
            end
            return b == ">";
        endfunction

        function void no_title();
            title_res_t r;
            r = '{8'h00, 7'd0, 1'b0, 1'b1};
            title_q = {title_q, r};
            done = 1;
        endfunction

        function void give_title();
            title_res_t r;
            int  n;
            bit  cut;
            bit [7:0] c;
            done = 1;
            n = mark_cnt;
            cut = n > 64;
            if (cut)
                n = 64;
            if (n == 0) begin
                r = '{8'h00, 7'd0, 1'b1, 1'b1};
                title_q = {title_q, r};
                return;
            end
            for (int k = 0; k < n; k++) begin
                c = (cut && k >= 61) ? 8'h2E : store[k % 64];
                if (white(c))
                    c = 8'h20;
                r = '{c, 7'(n), 1'b1, k + 1 == n};
                title_q = {title_q, r};
            end
        endfunction

        function bit [7:0] name_char(bit closing, bit [2:0] pos);
            string s;
            s = closing ? "/title" : "title";
            return s[pos];
        endfunction

        // accepted byte: advance the scanner and queue what it causes
        function void note_byte(bit [7:0] b, bit sof, bit eof);
            int tlen;
            if (sof)
                clear_file();
            if (done)
                return;
            if (open_seen) begin
                if (phase == PH_TEXT && b == "<")
                    mark_cnt = last_cnt;
                keep_byte(b);
            end
            case (phase)
                PH_TEXT: begin
                    if (b == 8'h0A) begin
                        if (lines < 17'h1FFFF)
                            lines++;
                        if (lines > line_limit) begin
                            no_title();
                            return;
                        end
                    end
                    if (b == "<") begin
                        phase = PH_AFTER_LT;
                        quote = 0;
                    end
                end
                PH_AFTER_LT: begin
                    if (b == "!") begin
                        phase = PH_CMT_PFX;
                        match_pos = 1;
                    end else if ((!open_seen && low_case(b) == "t") || (open_seen && b == "/")) begin
                        phase = PH_NAME;
                        match_pos = 1;
                    end else
                        phase = body_end(b) ? PH_TEXT : PH_BODY;
                end
                PH_CMT_PFX: begin
                    if (b == "-") begin
                        match_pos++;
                        if (match_pos >= 3)
                            phase = PH_CMT0;
                    end else
                        phase = body_end(b) ? PH_TEXT : PH_BODY;
                end
                PH_NAME: begin
                    tlen = open_seen ? 6 : 5;
                    if (match_pos < tlen && low_case(b) == name_char(open_seen, match_pos)) begin
                        match_pos++;
                        if (match_pos >= tlen)
                            phase = PH_NAMED_BODY;
                    end else
                        phase = body_end(b) ? PH_TEXT : PH_BODY;
                end
                PH_BODY: begin
                    if (body_end(b))
                        phase = PH_TEXT;
                end
                PH_NAMED_BODY: begin
                    if (body_end(b)) begin
                        if (!open_seen) begin
                            open_seen = 1;
                            cnt = 0;
                            last_cnt = 0;
                            mark_cnt = 0;
                            phase = PH_TEXT;
                        end else begin
                            give_title();
                            return;
                        end
                    end
                end
                PH_CMT0: begin
                    if (b == "-")
                        phase = PH_CMT1;
                end
                PH_CMT1: begin
                    if (b == "-")
                        phase = PH_CMT1;
                    else if (white(b))
                        phase = PH_CMT2;
                    else if (b == ">")
                        phase = PH_TEXT;
                    else
                        phase = PH_CMT0;
                end
                PH_CMT2: begin
                    if (white(b))
                        phase = PH_CMT2;
                    else if (b == ">")
                        phase = PH_TEXT;
                    else
                        phase = PH_CMT0;
                end
                default: phase = PH_TEXT;
            endcase
            if (eof) begin
                if (phase == PH_NAMED_BODY && open_seen)
                    give_title();
                else
                    no_title();
            end
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_title(bit [7:0] ch, bit [6:0] len, bit fnd, bit last);
            title_res_t e;
            if (title_q.size() == 0) begin
                $error("unexpected result char=%0h len=%0d found=%0b last=%0b",
                       ch, len, fnd, last);
                errors++;
                return;
            end
            e = title_q.pop_front();
            if (ch !== e.ch) begin
                $error("title_char expected %0h actual %0h", e.ch, ch);
                errors++;
            end
            if (len !== e.len) begin
                $error("title_length expected %0d actual %0d", e.len, len);
                errors++;
            end
            if (fnd !== e.fnd) begin
                $error("found expected %0b actual %0b", e.fnd, fnd);
                errors++;
            end
            if (last !== e.last) begin
                $error("is_last expected %0b actual %0b", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  text_byte;
    logic        start_of_file;
    logic        end_of_file;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  title_char;
    logic [6:0]  title_length;
    logic        found;
    logic        is_last;

    title_scoreboard sb = new();
    int snd_idle = 26;
    int rcv_idle = 69;
    int hold_left = 0;
    int items_sent = 0;
    bit [7:0] file_q [$];

    markup_title_extractor dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .text_byte(text_byte),
        .start_of_file(start_of_file), .end_of_file(end_of_file),
        .out_valid(out_valid), .out_stall(out_stall), .title_char(title_char),
        .title_length(title_length), .found(found), .is_last(is_last)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // receiver stall, with one long hold-off in the last phase
    always @(negedge clk)
    begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else
            out_stall <= ($urandom_range(99) < rcv_idle);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_title(title_char, title_length, found, is_last);
    end

    // offer one item and wait for it to be taken
    task automatic push_byte(bit [7:0] b, bit sof, bit eof);
        while ($urandom_range(99) < snd_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        text_byte <= b;
        start_of_file <= sof;
        end_of_file <= eof;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_byte(b, sof, eof);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic add_str(string s, bit mix_case);
        bit [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (mix_case && c >= "a" && c <= "z" && $urandom_range(1))
                c = c - 8'd32;
            file_q = {file_q, c};
        end
    endtask

    // send the built file; sof and eof may be left off on purpose
    task automatic send_file(bit sof, bit eof);
        for (int i = 0; i < file_q.size(); i++)
            push_byte(file_q[i], sof && i == 0, eof && i == file_q.size() - 1);
        file_q.delete();
    endtask

    task automatic drain_and_write(bit [15:0] v);
        in_valid <= 1'b0;
        while (sb.title_q.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.line_limit = v;
    endtask

    task automatic add_filler();
        case ($urandom_range(5))
            0: add_str("ab\n", 0);
            1: add_str("<!-- x -->", 0);
            2: add_str("<!--a-- \t>", 0);
            3: add_str("<a h=\">\" g='<'>", 0);
            4: add_str("<t>", 0);
            default: file_q = {file_q, 8'($urandom_range(255))};
        endcase
    endtask

    // random file: mostly well-formed title pages, some noise and broken ones
    task automatic random_file(int big);
        int n;
        int kind;
        kind = $urandom_range(9);
        if (kind == 0) begin
            n = $urandom_range(12, 1);
            repeat (n) file_q = {file_q, 8'($urandom)};
            send_file($urandom_range(5) != 0, $urandom_range(3) != 0);
            return;
        end
        repeat ($urandom_range(3)) add_filler();
        add_str("<title", 1);
        if ($urandom_range(2) == 0)
            add_str(" x='>'", 0);
        add_str(">", 0);
        n = big ? $urandom_range(140, 60) : $urandom_range(20);
        repeat (n) begin
            case ($urandom_range(7))
                0: file_q = {file_q, 8'h20};
                1: file_q = {file_q, 8'($urandom_range(13, 9))};
                2: file_q = {file_q, 8'($urandom)};
                3: add_str("<b>", 0);
                default: file_q = {file_q, 8'($urandom_range("z", "a"))};
            endcase
        end
        if (kind == 1) begin
            add_str("</title", 1);
            send_file(1, 1);
            return;
        end
        if (kind == 2) begin
            add_str("</ti", 1);
            send_file(1, 1);
            return;
        end
        add_str("</title>", 1);
        repeat ($urandom_range(2)) add_filler();
        send_file(kind != 3, 1);
    endtask

    // random files until about target more items have been taken
    task automatic random_phase(int target);
        int stop_at;
        stop_at = items_sent + target;
        while (items_sent < stop_at)
            random_file($urandom_range(7) == 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        text_byte = '0;
        start_of_file = 1'b0;
        end_of_file = 1'b0;
        out_stall = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // comment with spaced close, quoted '>', mixed case, eof inside the closing tag
        add_str("<!-- -- ><TiTle q='>'> A\tb </title", 0);
        send_file(1, 1);
        // empty title, then bytes after the answer are ignored
        add_str("<title></title>zz", 0);
        send_file(1, 1);
        // line limit exceeded
        drain_and_write(16'd0);
        add_str("\n<title>x", 0);
        send_file(1, 1);

        drain_and_write(16'hFFFF);
        random_phase(60);

        snd_idle = 69;
        rcv_idle = 26;
        drain_and_write(16'd0);
        random_phase(25);
        drain_and_write(16'($urandom_range(20, 1)));
        random_phase(40);

        snd_idle = 0;
        rcv_idle = 0;
        drain_and_write(16'd12);
        hold_left = 400;
        random_file(1);
        random_file(0);

        in_valid <= 1'b0;
        while (sb.title_q.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

>>> markup_title_extractor.f
+incdir+hdl
hdl/mte_pkg.sv
hdl/mte_ctrl.sv
hdl/mte_dp.sv
hdl/markup_title_extractor.sv
verif/markup_title_extractor_test.sv
